@@ sv/safs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_pkg
// Shared types and constants for the slot allocator with its LIFO free stack.
// ----------------------------------------------------------------------------
package safs_pkg;

  // Store size and the widths that follow from it
  localparam int MAX_SLOTS  = 1024;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  // largest log2 block size whose block still fits in the store
  localparam int FLOOR_LOG2 = $clog2(MAX_SLOTS + 1) - 1;
  localparam int L_W        = 5;
  localparam int SH_W       = CNT_W + FLOOR_LOG2;

  // Fixed field widths
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 4;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
  localparam logic [PADDR_W-1:0] ADDR_BLOCK_LOG2 = PADDR_W'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_QUERY     = 3'd2,
    CMD_MIGRATE   = 3'd3,
    CMD_ALLOC_AT  = 3'd4,
    CMD_MARK_DEAD = 3'd5,
    CMD_TRIM      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_LIVE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEAD      = 3'd3,
    ST_REFUSED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR  = 2'd0,
    S_IDLE   = 2'd1,
    S_EXEC   = 2'd2,
    S_WRITE2 = 2'd3
  } state_t;

endpackage

@@ sv/slot_allocator_free_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_allocator_free_stack
// Slot bookkeeping for a block-grown store: per-slot dead marks and a LIFO
// stack of freed indices, both held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           word
//  in        input      in_valid/in_ready   command, slot_index
//  out       output     out_valid/out_ready status, assigned_index, counts
//  cfg       APB        psel/penable/pready block_size_log2 at address 0
//
//  A command runs as the memory read at acceptance, then the
//  read-modify-write of dead marks, free stack and counters.
//  A successful migrate adds a second mark write in S_WRITE2, as the dead-mark
//  memory has one write port and the move writes two marks.
//  After reset a clearing pass over all MAX_SLOTS (1024) entries zeroes the dead
//  marks; no word is accepted until it ends. Configuration is taken at once.
//  A stalled output register holds the next command in the execute cycle.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [safs_pkg::CMD_W-1:0]     command,
  input  logic [safs_pkg::IDX_W-1:0]     slot_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [safs_pkg::STATUS_W-1:0]  status,
  output logic [safs_pkg::IDX_W-1:0]     assigned_index,
  output logic [safs_pkg::CNT_W-1:0]     live_count,
  output logic [safs_pkg::CNT_W-1:0]     freed_count,
  output logic [safs_pkg::CNT_W-1:0]     blocks_in_use,
  output logic [safs_pkg::CNT_W-1:0]     dropped_blocks,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [safs_pkg::PADDR_W-1:0]   paddr,
  input  logic [safs_pkg::PDATA_W-1:0]   pwdata,
  output logic [safs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import safs_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_SLOTS);
  localparam logic [L_W-1:0]   FLOOR_L = L_W'(FLOOR_LOG2);

  state_t             state, state_next;
  logic [IDX_W-1:0]   clr_addr;
  logic [CFG_W-1:0]   block_log2;

  cmd_t               cmd_q;
  logic [IDX_W-1:0]   idx_q;

  logic               dead_mem [MAX_SLOTS];
  logic [IDX_W-1:0]   stk_mem  [MAX_SLOTS];
  logic               dead_rd;
  logic [IDX_W-1:0]   stk_rd;

  logic [CNT_W-1:0]   free_top, item_total, block_total;

  logic               accept, out_free, commit;
  logic               dead_we, dead_wd, stk_we;
  logic [IDX_W-1:0]   dead_wa, stk_wa, stk_wd;

  // execute-stage results
  logic [STATUS_W-1:0] x_status;
  logic [IDX_W-1:0]    x_assigned, x_dead_wa;
  logic [CNT_W-1:0]    x_item, x_free, x_block, x_removed;
  logic                x_dead_we, x_dead_wd, x_stk_we, x_mig;

  // derived geometry
  logic [L_W-1:0]     eff_l;
  logic [SH_W-1:0]    cap_raw;
  logic [CNT_W-1:0]   cap, maxblk, need, last1;
  logic [CNT_W:0]     bound;
  logic               inb, idx_ok, grow_ok;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BLOCK_LOG2) ? PDATA_W'(block_log2) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_log2 <= CFG_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_BLOCK_LOG2) begin
      block_log2 <= pwdata[CFG_W-1:0];
    end
  end

  // FSM: next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == IDX_W'(MAX_SLOTS - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_EXEC;
      S_EXEC:   if (out_free) state_next = x_mig ? S_WRITE2 : S_IDLE;
      S_WRITE2: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    dead_we  = 1'b0;
    dead_wa  = x_dead_wa;
    dead_wd  = x_dead_wd;
    stk_we   = 1'b0;
    case (state)
      S_CLEAR: begin
        dead_we = 1'b1;
        dead_wa = clr_addr;
        dead_wd = 1'b0;
      end
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        commit  = out_free;
        dead_we = out_free && x_dead_we;
        stk_we  = out_free && x_stk_we;
      end
      S_WRITE2: begin
        dead_we = 1'b1;
        dead_wa = idx_q;
        dead_wd = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign stk_wa   = free_top[IDX_W-1:0];
  assign stk_wd   = idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      idx_q <= slot_index;
    end
  end

  // memories, read at acceptance
  always_ff @(posedge clk) begin
    if (dead_we) dead_mem[dead_wa] <= dead_wd;
    if (accept)  dead_rd <= dead_mem[slot_index];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (accept) stk_rd <= stk_mem[free_top[IDX_W-1:0] - IDX_W'(1)];
  end

  // geometry for the current block size
  always_comb begin
    eff_l   = (L_W'(block_log2) > FLOOR_L) ? FLOOR_L : L_W'(block_log2);
    cap_raw = SH_W'(block_total) << eff_l;
    cap     = (cap_raw > SH_W'(MAX_SLOTS)) ? MAX_C : cap_raw[CNT_W-1:0];
    maxblk  = MAX_C >> eff_l;
    need    = (CNT_W'(idx_q) >> eff_l) + CNT_W'(1);
    last1   = (item_total >> eff_l) + CNT_W'(1);
    bound   = {1'b0, item_total} + {1'b0, free_top};
    idx_ok  = CNT_W'(idx_q) < MAX_C;
    inb     = idx_ok && ((CNT_W + 1)'(idx_q) < bound);
    grow_ok = (CNT_W'(idx_q) < cap) || (need <= maxblk);
  end

  // execute: decide the command from the read data
  always_comb begin
    x_status  = ST_OK;
    x_assigned = '0;
    x_item    = item_total;
    x_free    = free_top;
    x_block   = block_total;
    x_removed = '0;
    x_dead_we = 1'b0;
    x_dead_wa = idx_q;
    x_dead_wd = 1'b0;
    x_stk_we  = 1'b0;
    x_mig     = 1'b0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (item_total >= MAX_C) begin
          x_status = ST_FULL;
        end else if (item_total >= cap && block_total >= maxblk) begin
          x_status = ST_FULL;
        end else begin
          if (item_total >= cap) x_block = block_total + CNT_W'(1);
          if (free_top != '0) begin
            x_free     = free_top - CNT_W'(1);
            x_assigned = stk_rd;
          end else begin
            x_assigned = item_total[IDX_W-1:0];
          end
          x_dead_we = 1'b1;
          x_dead_wa = x_assigned;
          x_item    = item_total + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (!inb) begin
          x_status = ST_NOT_LIVE;
        end else if (dead_rd) begin
          x_status = ST_DEAD;
        end else if (free_top >= MAX_C) begin
          x_status = ST_FULL;
        end else begin
          x_dead_we = 1'b1;
          x_dead_wd = 1'b1;
          x_stk_we  = 1'b1;
          x_free    = free_top + CNT_W'(1);
          if (item_total != '0) x_item = item_total - CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        if (!inb || dead_rd) x_status = ST_NOT_LIVE;
      end
      CMD_MIGRATE: begin
        if (!inb || dead_rd) begin
          x_status = ST_NOT_LIVE;
        end else if (free_top == '0 || stk_rd > idx_q) begin
          x_status = ST_REFUSED;
        end else begin
          // destination revived now, source marked dead in the next cycle
          x_dead_we  = 1'b1;
          x_dead_wa  = stk_rd;
          x_mig      = 1'b1;
          x_free     = free_top - CNT_W'(1);
          x_assigned = stk_rd;
        end
      end
      CMD_ALLOC_AT: begin
        if (!idx_ok) begin
          x_status = ST_NOT_LIVE;
        end else if (item_total >= MAX_C || !grow_ok) begin
          x_status = ST_FULL;
        end else begin
          if (CNT_W'(idx_q) >= cap && need > block_total) x_block = need;
          x_dead_we = 1'b1;
          x_item    = item_total + CNT_W'(1);
        end
      end
      CMD_MARK_DEAD: begin
        if (!idx_ok) begin
          x_status = ST_NOT_LIVE;
        end else if (free_top >= MAX_C || !grow_ok) begin
          x_status = ST_FULL;
        end else begin
          if (CNT_W'(idx_q) >= cap && need > block_total) x_block = need;
          x_dead_we = 1'b1;
          x_dead_wd = 1'b1;
          x_stk_we  = 1'b1;
          x_free    = free_top + CNT_W'(1);
        end
      end
      CMD_TRIM: begin
        // only a positive removal count shrinks the store
        if (block_total > last1) begin
          x_block   = last1;
          x_free    = '0;
          x_removed = block_total - last1;
        end
      end
      default: ;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top    <= '0;
      item_total  <= '0;
      block_total <= '0;
    end else if (commit) begin
      free_top    <= x_free;
      item_total  <= x_item;
      block_total <= x_block;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= x_status;
      assigned_index <= x_assigned;
      live_count     <= x_item;
      freed_count    <= x_free;
      blocks_in_use  <= x_block;
      dropped_blocks <= x_removed;
    end
  end

  // checks
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_top <= MAX_C)
    else $error("free stack depth beyond store size");

  a_item_bound: assert property (@(posedge clk) disable iff (rst)
    item_total <= MAX_C)
    else $error("live count beyond store size");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted word did not enter execute");

  a_write2_once: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE2 |=> state == S_IDLE)
    else $error("second mark write did not return to idle");

  a_blocks_grow: assert property (@(posedge clk) disable iff (rst)
    (commit && cmd_q != CMD_TRIM) |=> block_total >= $past(block_total))
    else $error("capacity shrank outside trim");

endmodule
